// ----- src/assert_macros.svh -----
// Assertion macros included by the pick core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- src/mwrp_pkg.sv -----
// Package: operation codes, field widths and sequencer states of the weighted pick core
package mwrp_pkg;

    // Field widths of the request and result channels
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 16;
    localparam int RAND_W   = 32;
    localparam int PICK_W   = 7;
    localparam int MASK_W   = 9;

    // Shared multiplier operand widths
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Mask factor of 1.0
    localparam logic [MASK_W-1:0] MASK_ONE = 9'd256;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_SET_WEIGHT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_MASK    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_MASKS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DRAW        = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_WEIGHT = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPD_OLD,
        ST_UPD_NEW,
        ST_UPD_ADD,
        ST_RD_WAIT,
        ST_CLR_RD,
        ST_CLR_ACC,
        ST_SCALE_MUL,
        ST_SCALE_ACC,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ----- src/masked_weighted_random_pick_core.sv -----
// Masked weighted random pick core: weight/mask table, masked total and roulette draw
// One request at a time; the draw walk streams one entry a cycle through the table memory
//   read port and the shared multiplier, the clear sweep reads each entry and then writes it back.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous) is followed by a pass that writes weight 1 and mask 1.0
//   into every entry; s_ready stays low until it ends.
`include "assert_macros.svh"

module masked_weighted_random_pick_core #(
    parameter int TABLE_ENTRIES = 64,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mwrp_pkg::FUNC_W-1:0]    s_func,
    input  logic [mwrp_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic [mwrp_pkg::VALUE_W-1:0]   s_new_value,
    input  logic [mwrp_pkg::RAND_W-1:0]    s_random_draw,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mwrp_pkg::PICK_W-1:0]    m_picked_index,
    output logic [mwrp_pkg::VALUE_W-1:0]   m_weight_read,
    output logic                           m_status
);
    import mwrp_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int SUM_W   = WEIGHT_BITS + $clog2(TABLE_ENTRIES + 1);
    localparam int NCH     = (SUM_W + MUL_B_W - 1) / MUL_B_W;
    localparam int CH_W    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PAD_W   = NCH * MUL_B_W;
    localparam int ACC_W   = RAND_W + PAD_W;
    localparam int ENTRY_W = WEIGHT_BITS + MASK_W;
    localparam int RANGE_W = 11;

    // Sequencer
    state_t state_reg, state_next;

    // Latched request
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [RAND_W-1:0]  rnd_reg, rnd_next;

    // Counters and arithmetic state
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CH_W-1:0]    chunk_reg, chunk_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SUM_W-1:0]   target_reg, target_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [ENTRY_W-1:0] new_entry_reg, new_entry_next;

    // Walk pipeline tags
    logic               v1_reg, v1_next, v2_reg, v2_next;
    logic [IDX_W-1:0]   k1_reg, k1_next, k2_reg, k2_next;

    // Result staging and output register
    logic [PICK_W-1:0]  res_pick_reg, res_pick_next;
    logic [VALUE_W-1:0] res_weight_reg, res_weight_next;
    logic               res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [PICK_W-1:0]  m_picked_index_reg, m_picked_index_next;
    logic [VALUE_W-1:0] m_weight_read_reg, m_weight_read_next;
    logic               m_status_reg, m_status_next;

    // Table memory ports
    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data_reg;

    // Decoded helpers
    logic                   accept;
    logic                   inside_range;
    logic [WEIGHT_BITS-1:0] rd_w, new_w, mw;
    logic [MASK_W-1:0]      rd_m, new_m;
    logic [32:0]            wmax, val_ext;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PAD_W-1:0]       sum_pad;
    logic [ACC_W-1:0]       acc_step;
    logic                   walk_hit, walk_last, walk_issue;

    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign inside_range = {4'b0, s_entry_index} < RANGE_W'(TABLE_ENTRIES);

    assign rd_w = rd_data_reg[WEIGHT_BITS-1:0];
    assign rd_m = rd_data_reg[ENTRY_W-1:WEIGHT_BITS];

    // Saturate incoming weight and mask values
    assign wmax    = (33'd1 << WEIGHT_BITS) - 33'd1;
    assign val_ext = 33'(val_reg);
    assign new_w   = (val_ext > wmax) ? WEIGHT_BITS'(wmax) : WEIGHT_BITS'(val_reg);
    assign new_m   = (val_reg > 16'(MASK_ONE)) ? MASK_ONE : MASK_W'(val_reg);

    // Masked weight from the registered product
    assign mw = WEIGHT_BITS'(prod_reg >> 8);

    // Scaling: one 16-bit slice of the total per pass, most significant first
    assign sum_pad  = PAD_W'(sum_reg);
    assign acc_step = {acc_reg[ACC_W-MUL_B_W-1:0], {MUL_B_W{1'b0}}} + ACC_W'(prod_reg);

    // Walk compare stage
    assign walk_issue = (state_reg == ST_WALK) && (cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign walk_hit   = v2_reg && (target_reg < SUM_W'(mw));
    assign walk_last  = v2_reg && (k2_reg == IDX_W'(TABLE_ENTRIES - 1));

    // Select shared multiplier operands
    always_comb begin
        case (state_reg)
            ST_SCALE_MUL: begin
                mul_a = rnd_reg;
                mul_b = sum_pad[MUL_B_W*chunk_reg +: MUL_B_W];
            end
            ST_UPD_NEW: begin
                mul_a = MUL_A_W'(new_entry_reg[WEIGHT_BITS-1:0]);
                mul_b = MUL_B_W'(new_entry_reg[ENTRY_W-1:WEIGHT_BITS]);
            end
            default: begin
                mul_a = MUL_A_W'(rd_w);
                mul_b = MUL_B_W'(rd_m);
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FUNC_SET_WEIGHT, FUNC_SET_MASK:
                            state_next = inside_range ? ST_UPD_OLD : ST_DONE;
                        FUNC_READ_WEIGHT:
                            state_next = inside_range ? ST_RD_WAIT : ST_DONE;
                        FUNC_CLEAR_MASKS: state_next = ST_CLR_RD;
                        FUNC_DRAW:        state_next = ST_SCALE_MUL;
                        default:          state_next = ST_DONE;
                    endcase
                end
            end
            ST_UPD_OLD:   state_next = ST_UPD_NEW;
            ST_UPD_NEW:   state_next = ST_UPD_ADD;
            ST_UPD_ADD:   state_next = ST_DONE;
            ST_RD_WAIT:   state_next = ST_DONE;
            ST_CLR_RD:    state_next = ST_CLR_ACC;
            ST_CLR_ACC: begin
                state_next = (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) ? ST_DONE : ST_CLR_RD;
            end
            ST_SCALE_MUL: state_next = ST_SCALE_ACC;
            ST_SCALE_ACC: state_next = (chunk_reg == '0) ? ST_WALK : ST_SCALE_MUL;
            ST_WALK: begin
                if (walk_hit || walk_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result outputs
    always_comb begin
        func_next           = func_reg;
        idx_next            = idx_reg;
        val_next            = val_reg;
        rnd_next            = rnd_reg;
        cnt_next            = cnt_reg;
        chunk_next          = chunk_reg;
        acc_next            = acc_reg;
        target_next         = target_reg;
        sum_next            = sum_reg;
        new_entry_next      = new_entry_reg;
        v1_next             = 1'b0;
        v2_next             = 1'b0;
        k1_next             = k1_reg;
        k2_next             = k2_reg;
        res_pick_next       = res_pick_reg;
        res_weight_next     = res_weight_reg;
        res_status_next     = res_status_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_picked_index_next = m_picked_index_reg;
        m_weight_read_next  = m_weight_read_reg;
        m_status_next       = m_status_reg;
        rd_en               = 1'b0;
        rd_addr             = IDX_W'(s_entry_index);
        wr_en               = 1'b0;
        wr_addr             = idx_reg;
        wr_data             = new_entry_reg;

        case (state_reg)
            // Write weight one and mask 1.0 into every entry after reset
            ST_INIT: begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(cnt_reg);
                wr_data  = {MASK_ONE, WEIGHT_BITS'(1)};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1)) begin
                    sum_next = SUM_W'(TABLE_ENTRIES);
                end
            end
            // Latch the request and start its first step
            ST_IDLE: begin
                if (accept) begin
                    func_next       = s_func;
                    idx_next        = IDX_W'(s_entry_index);
                    val_next        = s_new_value;
                    rnd_next        = s_random_draw;
                    res_pick_next   = '0;
                    res_weight_next = '0;
                    res_status_next = 1'b0;
                    if (s_func inside {FUNC_SET_WEIGHT, FUNC_SET_MASK, FUNC_READ_WEIGHT}) begin
                        rd_en           = inside_range;
                        res_status_next = !inside_range;
                    end
                    if (s_func == FUNC_CLEAR_MASKS) begin
                        cnt_next = '0;
                        sum_next = '0;
                    end
                    if (s_func == FUNC_DRAW) begin
                        acc_next   = '0;
                        chunk_next = CH_W'(NCH - 1);
                    end
                end
            end
            // Form the new entry while the old masked weight is multiplied
            ST_UPD_OLD: begin
                new_entry_next = (func_reg == FUNC_SET_WEIGHT) ? {rd_m, new_w} : {new_m, rd_w};
            end
            // Drop the old masked weight, store the entry, multiply the new one
            ST_UPD_NEW: begin
                sum_next = sum_reg - SUM_W'(mw);
                wr_en    = 1'b1;
            end
            ST_UPD_ADD: begin
                sum_next = sum_reg + SUM_W'(mw);
            end
            ST_RD_WAIT: begin
                res_weight_next = VALUE_W'(rd_w);
            end
            // Clear sweep: read an entry, then write it back unmasked and add its weight
            ST_CLR_RD: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(cnt_reg);
            end
            ST_CLR_ACC: begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(cnt_reg);
                wr_data  = {MASK_ONE, rd_w};
                sum_next = sum_reg + SUM_W'(rd_w);
                cnt_next = cnt_reg + CNT_W'(1);
            end
            // Accumulate random value times the total, one slice per pass
            ST_SCALE_ACC: begin
                acc_next   = acc_step;
                chunk_next = chunk_reg - CH_W'(1);
                if (chunk_reg == '0) begin
                    target_next = SUM_W'(acc_step >> RAND_W);
                    cnt_next    = '0;
                end
            end
            // Stream entries: read, multiply, compare and subtract
            ST_WALK: begin
                rd_en   = walk_issue;
                rd_addr = IDX_W'(cnt_reg);
                if (walk_issue) cnt_next = cnt_reg + CNT_W'(1);
                v1_next = walk_issue;
                k1_next = IDX_W'(cnt_reg);
                v2_next = v1_reg;
                k2_next = k1_reg;
                if (v2_reg) begin
                    if (walk_hit) begin
                        res_pick_next = PICK_W'(k2_reg);
                    end else begin
                        target_next = target_reg - SUM_W'(mw);
                        if (walk_last) res_pick_next = PICK_W'(TABLE_ENTRIES);
                    end
                end
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_picked_index_next = res_pick_reg;
                    m_weight_read_next  = res_weight_reg;
                    m_status_next       = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Table memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        func_reg           <= func_next;
        idx_reg            <= idx_next;
        val_reg            <= val_next;
        rnd_reg            <= rnd_next;
        chunk_reg          <= chunk_next;
        acc_reg            <= acc_next;
        target_reg         <= target_next;
        sum_reg            <= sum_next;
        prod_reg           <= PROD_W'(mul_a) * PROD_W'(mul_b);
        new_entry_reg      <= new_entry_next;
        k1_reg             <= k1_next;
        k2_reg             <= k2_next;
        res_pick_reg       <= res_pick_next;
        res_weight_reg     <= res_weight_next;
        res_status_reg     <= res_status_next;
        m_picked_index_reg <= m_picked_index_next;
        m_weight_read_reg  <= m_weight_read_next;
        m_status_reg       <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_picked_index = m_picked_index_reg;
    assign m_weight_read  = m_weight_read_reg;
    assign m_status       = m_status_reg;

    // Checks on the sequencer and the running total
    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE, "request accepted but sequencer stayed idle")
    `ASSERT_IMPLIES(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_DONE, "result raised outside the done state")
    `ASSERT_IMPLIES(a_sum_bounded, aclk, aresetn, state_reg == ST_IDLE, 64'(sum_reg) <= 64'(TABLE_ENTRIES) * ((64'd1 << WEIGHT_BITS) - 64'd1), "masked total above its bound")
    `ASSERT_IMPLIES(a_walk_tag_range, aclk, aresetn, state_reg == ST_WALK && v2_reg, 32'(k2_reg) < 32'(TABLE_ENTRIES), "walk compare on an index past the table")

endmodule
